// File: sv/ppt_pkg.sv
// shared types, widths and constants of the pulse period tachometer
package ppt_pkg;

    // measurement tick rate and derived numerators
    localparam longint unsigned TICK_RATE_HZ = 64'd1000000;
    localparam longint unsigned RPM_NUM      = 64'd60 * TICK_RATE_HZ;
    localparam longint unsigned SPD_NUM_MAX  = 64'd65535 * TICK_RATE_HZ;
    localparam longint unsigned MM_PER_M     = 64'd1000;

    // field widths
    localparam int TICKS_W  = 17;
    localparam int PERIOD_W = TICKS_W + 1;
    localparam int RPM_W    = 16;
    localparam int PPR_W    = 8;
    localparam int CIRC_W   = 16;
    localparam int VAL_W    = 16;
    localparam int Q_W      = VAL_W;

    // divider widths
    localparam int NUM_W  = (RPM_NUM > SPD_NUM_MAX) ? $clog2(RPM_NUM + 64'd1)
                                                    : $clog2(SPD_NUM_MAX + 64'd1);
    localparam int PROD_W = PPR_W + PERIOD_W;
    localparam int DEN_W  = PROD_W + $clog2(MM_PER_M + 64'd1);
    localparam int DSH_W  = DEN_W + Q_W - 1;
    localparam int CMP_W  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
    localparam int CNT_W  = $clog2(Q_W);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICKS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TMO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TMO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC     = 3'd4;

    // configuration register file
    typedef struct packed {
        logic [TICKS_W-1:0] high_timeout_ticks;
        logic [TICKS_W-1:0] low_timeout_ticks;
        logic [RPM_W-1:0]   rpm_limit;
        logic [PPR_W-1:0]   pulses_per_rev;
        logic [CIRC_W-1:0]  circumference_mm;
    } cfg_t;

    // tracker events for the current beat
    typedef struct packed {
        logic complete;
        logic timeout;
    } evt_t;

    // controller to datapath commands
    typedef struct packed {
        logic ld_tmo;
        logic ld_rpm;
        logic ld_spd;
        logic div_step;
        logic ld_meas;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_valid;
    } stat_t;

endpackage

// File: sv/ppt_in_if.sv
// tick channel: valid, ready and the sampled pin level
interface ppt_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

// File: sv/ppt_out_if.sv
// result channel: valid, ready and the measurement result
interface ppt_out_if;
    import ppt_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] rpm_value;
    logic [VAL_W-1:0] speed_value;
    logic             timed_out;

    modport source (output valid, output rpm_value, output speed_value,
                    output timed_out, input ready);
    modport sink   (input valid, input rpm_value, input speed_value,
                    input timed_out, output ready);
endinterface

// File: sv/ppt_tracker.sv
// pin phase tracker: edge detection, phase counters and timeouts
module ppt_tracker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         level,
    input  ppt_pkg::cfg_t                cfg,
    output ppt_pkg::evt_t                evt,
    output logic [ppt_pkg::PERIOD_W-1:0] period
);
    import ppt_pkg::*;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [TICKS_W-1:0] TICKS_MAX = '1;
    localparam logic [TICKS_W-1:0] TICKS_ONE = TICKS_W'(1);

    logic [1:0]         phase_reg, phase_next;
    logic               last_reg, last_next;
    logic [TICKS_W-1:0] pt_reg, pt_next;
    logic [TICKS_W-1:0] high_reg, high_next;
    logic [TICKS_W-1:0] low_reg, low_next;
    logic [TICKS_W-1:0] pt_inc;

    assign pt_inc = (pt_reg == TICKS_MAX) ? pt_reg : pt_reg + TICKS_ONE;

    // period from both phases, held while the result is computed
    assign period = PERIOD_W'(high_reg) + PERIOD_W'(low_reg);

    // one tick of the phase tracker
    always_comb
    begin
        phase_next   = phase_reg;
        last_next    = level;
        pt_next      = pt_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        evt.complete = 1'b0;
        evt.timeout  = 1'b0;
        case (phase_reg)
            PH_LOW:
            begin
                if (level)
                begin
                    evt.complete = 1'b1;
                    phase_next   = PH_WAIT;
                    pt_next      = '0;
                end
                else
                begin
                    low_next = (low_reg == TICKS_MAX) ? low_reg : low_reg + TICKS_ONE;
                    pt_next  = pt_inc;
                    if (pt_inc >= cfg.low_timeout_ticks)
                    begin
                        evt.timeout = 1'b1;
                        phase_next  = PH_WAIT;
                        pt_next     = '0;
                    end
                end
            end
            PH_HIGH:
            begin
                if (!level)
                begin
                    phase_next = PH_LOW;
                    low_next   = TICKS_ONE;
                    pt_next    = TICKS_ONE;
                    if (TICKS_ONE >= cfg.low_timeout_ticks)
                    begin
                        evt.timeout = 1'b1;
                        phase_next  = PH_WAIT;
                        pt_next     = '0;
                    end
                end
                else
                begin
                    high_next = (high_reg == TICKS_MAX) ? high_reg : high_reg + TICKS_ONE;
                    pt_next   = pt_inc;
                    if (pt_inc >= cfg.high_timeout_ticks)
                    begin
                        evt.timeout = 1'b1;
                        phase_next  = PH_WAIT;
                        pt_next     = '0;
                    end
                end
            end
            default:
            begin
                // waiting, and the unused code behaves the same
                phase_next = PH_WAIT;
                if (!last_reg && level)
                begin
                    phase_next = PH_HIGH;
                    high_next  = TICKS_ONE;
                    low_next   = '0;
                end
                pt_next = pt_inc;
                if (pt_inc >= cfg.high_timeout_ticks)
                begin
                    evt.timeout = 1'b1;
                    phase_next  = PH_WAIT;
                    pt_next     = '0;
                end
            end
        endcase
    end

    // tracker state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            last_reg  <= 1'b1;
            pt_reg    <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
            pt_reg    <= pt_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
        end
    end

endmodule

// File: sv/ppt_datapath.sv
// result datapath: products, shared restoring divider and output register
module ppt_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ppt_pkg::cfg_t                cfg,
    input  logic [ppt_pkg::PERIOD_W-1:0] period,
    input  ppt_pkg::cmd_t                cmd,
    output ppt_pkg::stat_t               st,
    ppt_out_if.source                    result
);
    import ppt_pkg::*;

    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    logic [PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]  snum_reg;
    logic [DEN_W-1:0]  sden_reg;
    logic              spd_zero_reg;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DSH_W-1:0]  dsh_reg, dsh_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [Q_W-1:0]    rpm_q_reg;
    logic              rpm_ovf_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  rpm_out_reg, spd_out_reg;
    logic              tmo_out_reg;

    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [CMP_W-1:0]  rem_ext, dsh_ext, diff;
    logic              ge;
    logic [VAL_W-1:0]  rpm_final, spd_final;

    // divider operands: rpm uses the bare period, speed the scaled product
    assign div_num = cmd.ld_spd ? snum_reg : NUM_W'(RPM_NUM);
    assign div_den = cmd.ld_spd ? sden_reg : DEN_W'(period);

    // one quotient bit per step
    assign rem_ext = CMP_W'(rem_reg);
    assign dsh_ext = CMP_W'(dsh_reg);
    assign ge      = rem_ext >= dsh_ext;
    assign diff    = rem_ext - dsh_ext;

    always_comb
    begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        if (cmd.ld_rpm || cmd.ld_spd)
        begin
            // quotient of 2^16 or more is caught up front
            rem_next = div_num;
            dsh_next = DSH_W'(div_den) << (Q_W - 1);
            q_next   = '0;
            ovf_next = CMP_W'(div_num) >= (CMP_W'(div_den) << Q_W);
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_next = diff[NUM_W-1:0];
            end
            q_next   = {q_reg[Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    // operand products: pulse-count product and speed numerator at the rpm load, scaled denominator on divider steps
    always_ff @(posedge clk)
    begin
        if (cmd.ld_rpm)
        begin
            prod_reg     <= PROD_W'(cfg.pulses_per_rev) * PROD_W'(period);
            snum_reg     <= NUM_W'(cfg.circumference_mm) * NUM_W'(TICK_RATE_HZ);
            spd_zero_reg <= (cfg.pulses_per_rev == '0);
        end
        if (cmd.div_step)
        begin
            sden_reg <= DEN_W'(prod_reg) * DEN_W'(MM_PER_M);
        end
        if (cmd.ld_spd)
        begin
            rpm_q_reg   <= q_reg;
            rpm_ovf_reg <= ovf_reg;
        end
    end

    // limit and saturation of the finished quotients
    assign rpm_final = (rpm_ovf_reg || (rpm_q_reg >= cfg.rpm_limit)) ? '0 : rpm_q_reg;
    assign spd_final = spd_zero_reg ? '0 : (ovf_reg ? VAL_MAX : q_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_tmo || cmd.ld_meas)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_tmo)
        begin
            rpm_out_reg <= '0;
            spd_out_reg <= '0;
            tmo_out_reg <= 1'b1;
        end
        else if (cmd.ld_meas)
        begin
            rpm_out_reg <= rpm_final;
            spd_out_reg <= spd_final;
            tmo_out_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.rpm_value   = rpm_out_reg;
    assign result.speed_value = spd_out_reg;
    assign result.timed_out   = tmo_out_reg;
    assign st.out_valid       = out_valid_reg;

endmodule

// File: sv/ppt_ctrl.sv
// controller: tick acceptance and sequencing of the result computation
module ppt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    input  ppt_pkg::evt_t  evt,
    input  ppt_pkg::stat_t st,
    output ppt_pkg::cmd_t  cmd
);
    import ppt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD_R = 3'd1;
    localparam logic [2:0] S_DIV_R  = 3'd2;
    localparam logic [2:0] S_LOAD_S = 3'd3;
    localparam logic [2:0] S_DIV_S  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             slot_free;
    logic             in_acc;

    assign slot_free = !st.out_valid || out_ready;
    assign in_acc    = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = slot_free;
                cmd.ld_tmo = in_valid && slot_free && evt.timeout;
                if (in_valid && slot_free && evt.complete)
                begin
                    state_next = S_LOAD_R;
                end
            end
            S_LOAD_R:
            begin
                cmd.ld_rpm = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV_R;
            end
            S_DIV_R:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_LOAD_S;
                end
            end
            S_LOAD_S:
            begin
                cmd.ld_spd = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV_S;
            end
            S_DIV_S:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.ld_meas = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ld_tmo || cmd.ld_meas) |-> slot_free)
        else $error("result register overwritten before delivery");

    // a completing beat always starts the rpm division
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && evt.complete) |=> (state_reg == S_LOAD_R))
        else $error("completed measurement did not start the division");

    // rpm division runs its full count before the speed division
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_R && cnt_reg == CNT_LAST) |=> (state_reg == S_LOAD_S))
        else $error("rpm division ended at the wrong step");

    // a completion and a timeout never come from the same beat
    a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !(evt.complete && evt.timeout))
        else $error("completion and timeout on one beat");

endmodule

// File: sv/pulse_period_tachometer_core.sv
// Pulse period tachometer top level: configuration registers, tracker,
// controller and datapath. Each tick beat carries the sampled tach pin level
// and is normally accepted as soon as it is offered; a tick that ends a
// period by a rising edge starts the rpm and speed computation, which holds
// the tick channel off through a load and 16 divider steps for rpm, a load
// and 16 steps for speed and the output load, on the shared one-bit-per-cycle
// restoring divider. A timeout gives its result on the beat itself. One result
// register sits on the output; ticks are taken while it is empty or being
// taken, and otherwise wait. Configuration writes take effect at once.
module pulse_period_tachometer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    ppt_in_if.sink                         tick,
    ppt_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppt_pkg::*;

    cfg_t                cfg_reg;
    evt_t                evt;
    cmd_t                cmd;
    stat_t               st;
    logic [PERIOD_W-1:0] period;
    logic                in_ready;
    logic                step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_timeout_ticks <= TICKS_W'(65000);
            cfg_reg.low_timeout_ticks  <= TICKS_W'(125000);
            cfg_reg.rpm_limit          <= RPM_W'(13500);
            cfg_reg.pulses_per_rev     <= PPR_W'(6);
            cfg_reg.circumference_mm   <= CIRC_W'(1000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_TMO: cfg_reg.high_timeout_ticks <= cfg_data[TICKS_W-1:0];
                CFG_LOW_TMO:  cfg_reg.low_timeout_ticks  <= cfg_data[TICKS_W-1:0];
                CFG_RPM_LIM:  cfg_reg.rpm_limit          <= cfg_data[RPM_W-1:0];
                CFG_PPR:      cfg_reg.pulses_per_rev     <= cfg_data[PPR_W-1:0];
                CFG_CIRC:     cfg_reg.circumference_mm   <= cfg_data[CIRC_W-1:0];
                default:      ;
            endcase
        end
    end

    // tick beat handshake
    assign tick.ready = in_ready;
    assign step       = tick.valid && in_ready;

    ppt_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .level  (tick.pin_level),
        .cfg    (cfg_reg),
        .evt    (evt),
        .period (period)
    );

    ppt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .evt       (evt),
        .st        (st),
        .cmd       (cmd)
    );

    ppt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .period (period),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

endmodule
